// File: rtl/hcidf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcidf_pkg;

   // H4 packet indicators that open a packet.
   localparam logic [7:0] IND_ACL   = 8'h02;
   localparam logic [7:0] IND_EVENT = 8'h04;

   // Position of the length byte and the bytes added to it for the total.
   localparam logic [8:0] ACL_LEN_POS = 9'd3;
   localparam logic [8:0] ACL_EXTRA   = 9'd5;
   localparam logic [8:0] EVT_LEN_POS = 9'd2;
   localparam logic [8:0] EVT_EXTRA   = 9'd3;

   // Packet kinds as they appear on the result channel.
   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_ACL   = 1'b1;

   // Deframer phase; the fourth code is unused and behaves as hunting.
   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   // Fields of one result item.
   typedef struct packed {
      logic [7:0] frame_byte;
      logic [8:0] byte_index;
      logic       packet_kind;
      logic       kept;
      logic       is_last;
      logic [8:0] frame_length;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/hcidf_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel that carries received UART bytes into the deframer.
interface hcidf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

// Channel that carries packet bytes out of the deframer.
interface hcidf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic [8:0] byte_index;
   logic       packet_kind;
   logic       kept;
   logic       is_last;
   logic [8:0] frame_length;

   modport source (output valid, output frame_byte, output byte_index, output packet_kind,
                   output kept, output is_last, output frame_length, input ready);
   modport sink (input valid, input frame_byte, input byte_index, input packet_kind,
                 input kept, input is_last, input frame_length, output ready);
endinterface

`default_nettype wire

// File: rtl/hcidf_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hcidf_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   output      logic       in_ready,
   input  wire logic       advance,
   output      logic       held_valid,
   output      logic [7:0] held_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // The register takes a new item when it is empty or its item moves on.
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

`default_nettype wire

// File: rtl/hcidf_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module hcidf_parser #(
   parameter int KEEP_BYTES = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             byte_in,
   input  wire logic                   step,
   output      logic                   has_result,
   output      hcidf_pkg::result_type  result
);

   localparam logic [9:0] KeepLimit = 10'(KEEP_BYTES);

   hcidf_pkg::phase_type phase_ff, phase_in;
   logic       kind_ff, kind_in;
   logic [8:0] count_ff, count_in;
   logic [8:0] total_ff, total_in;

   logic       kind_cur;
   logic [8:0] idx;
   logic [8:0] len_pos;
   logic [8:0] extra;
   logic [8:0] total_cur;
   logic       in_body;
   logic       last;

   assign len_pos = kind_ff ? hcidf_pkg::ACL_LEN_POS : hcidf_pkg::EVT_LEN_POS;
   assign extra   = kind_ff ? hcidf_pkg::ACL_EXTRA : hcidf_pkg::EVT_EXTRA;

   // Next state and the result for the byte in the input register.
   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      kind_cur   = kind_ff;
      idx        = count_ff;
      total_cur  = total_ff;
      in_body    = 1'b0;
      last       = 1'b0;
      has_result = 1'b0;

      unique case (phase_ff)
         hcidf_pkg::PH_HEAD, hcidf_pkg::PH_BODY: begin
            has_result = 1'b1;
            in_body    = (phase_ff == hcidf_pkg::PH_BODY);
            // The length byte fixes the total and opens the body.
            if (phase_ff == hcidf_pkg::PH_HEAD && idx == len_pos) begin
               total_cur = 9'(byte_in) + extra;
               in_body   = 1'b1;
            end
            last     = in_body && ({1'b0, idx} + 10'd1 >= {1'b0, total_cur});
            total_in = total_cur;
            if (last) begin
               phase_in = hcidf_pkg::PH_HUNT;
               count_in = 9'd0;
            end else begin
               phase_in = in_body ? hcidf_pkg::PH_BODY : hcidf_pkg::PH_HEAD;
               count_in = idx + 9'd1;
            end
         end
         default: begin
            // Hunting: only an indicator starts a packet.
            phase_in = hcidf_pkg::PH_HUNT;
            if (byte_in == hcidf_pkg::IND_ACL || byte_in == hcidf_pkg::IND_EVENT) begin
               has_result = 1'b1;
               kind_cur   = (byte_in == hcidf_pkg::IND_ACL) ? hcidf_pkg::KIND_ACL
                                                           : hcidf_pkg::KIND_EVENT;
               kind_in    = kind_cur;
               idx        = 9'd0;
               count_in   = 9'd1;
               total_in   = 9'd0;
               phase_in   = hcidf_pkg::PH_HEAD;
            end
         end
      endcase

      result.frame_byte   = byte_in;
      result.byte_index   = idx;
      result.packet_kind  = kind_cur;
      result.kept         = ({1'b0, idx} < KeepLimit);
      result.is_last      = last;
      result.frame_length = last ? total_cur : 9'd0;
   end

   // State register, updated only when the item leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hcidf_pkg::PH_HUNT;
         kind_ff  <= 1'b0;
         count_ff <= 9'd0;
         total_ff <= 9'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/hcidf_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hcidf_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire hcidf_pkg::result_type result,
   output      logic                  slot_free,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      hcidf_pkg::result_type out_data
);

   logic                  valid_ff;
   logic                  valid_in;
   hcidf_pkg::result_type data_ff;

   // A slot is free when empty or when its item is taken this cycle.
   assign slot_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/hci_uart_packet_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Bluetooth HCI H4 deframer for a received UART byte stream. Bytes are taken
// on req_if and every byte of an ACL data (0x02) or event (0x04) packet comes
// out on rsp_if with its index, the packet kind, a kept flag (index below
// KEEP_BYTES) and, on the final byte, the total packet length; bytes outside
// a packet are dropped. The block accepts one byte per clock cycle; an
// accepted byte waits in the input register and its result in the result
// register, with the packet state updated in a single pass between them.
// Result backpressure stalls input only when the result register is full
// and not being taken.
module hci_uart_packet_deframer_core #(
   parameter int KEEP_BYTES = 128
) (
   input  wire logic clock,
   input  wire logic reset,
   hcidf_req_if.sink   req_if,
   hcidf_rsp_if.source rsp_if
);

   logic                  held_valid;
   logic [7:0]            held_byte;
   logic                  advance;
   logic                  has_result;
   logic                  slot_free;
   hcidf_pkg::result_type result;
   hcidf_pkg::result_type out_data;

   // An item moves on when it makes no result or the result slot is free.
   assign advance = held_valid && (!has_result || slot_free);

   hcidf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_byte    (req_if.byte_in),
      .in_ready   (req_if.ready),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   hcidf_parser #(
      .KEEP_BYTES (KEEP_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_in    (held_byte),
      .step       (advance),
      .has_result (has_result),
      .result     (result)
   );

   hcidf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && has_result),
      .result    (result),
      .slot_free (slot_free),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_data)
   );

   assign rsp_if.frame_byte   = out_data.frame_byte;
   assign rsp_if.byte_index   = out_data.byte_index;
   assign rsp_if.packet_kind  = out_data.packet_kind;
   assign rsp_if.kept         = out_data.kept;
   assign rsp_if.is_last      = out_data.is_last;
   assign rsp_if.frame_length = out_data.frame_length;

endmodule

`default_nettype wire

// File: rtl/hcidf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hcidf_checker #(
   parameter int KEEP_BYTES = 128
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_frame_byte,
   input wire logic [8:0] rsp_byte_index,
   input wire logic       rsp_packet_kind,
   input wire logic       rsp_kept,
   input wire logic       rsp_is_last,
   input wire logic [8:0] rsp_frame_length
);

   localparam logic [9:0] KeepLimit = 10'(KEEP_BYTES);

   // A stalled result item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_byte_index) && $stable(rsp_is_last))
      else $error("stalled result item changed");

   // The final byte sits at the end of the packet length; others carry no length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_last
         ? ({1'b0, rsp_byte_index} + 10'd1 == {1'b0, rsp_frame_length})
         : (rsp_frame_length == 9'd0)))
      else $error("packet length does not match last byte");

   // A packet opens with an indicator that sets its kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_index == 9'd0 |->
         (rsp_frame_byte == hcidf_pkg::IND_ACL && rsp_packet_kind == hcidf_pkg::KIND_ACL)
         || (rsp_frame_byte == hcidf_pkg::IND_EVENT
             && rsp_packet_kind == hcidf_pkg::KIND_EVENT))
      else $error("packet start is not an indicator of its kind");

   // Kept follows the keep limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kept == ({1'b0, rsp_byte_index} < KeepLimit))
      else $error("kept flag disagrees with byte index");

   // Indexes within a packet advance by one from item to item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_last ##1 rsp_valid |->
         rsp_byte_index == $past(rsp_byte_index) + 9'd1)
      else $error("byte index skipped within a packet");

endmodule

bind hci_uart_packet_deframer_core hcidf_checker #(
   .KEEP_BYTES (KEEP_BYTES)
) u_hcidf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_frame_byte   (rsp_if.frame_byte),
   .rsp_byte_index   (rsp_if.byte_index),
   .rsp_packet_kind  (rsp_if.packet_kind),
   .rsp_kept         (rsp_if.kept),
   .rsp_is_last      (rsp_if.is_last),
   .rsp_frame_length (rsp_if.frame_length)
);

`default_nettype wire

// File: dv/hci_uart_packet_deframer_core_test.sv
`timescale 1ns / 1ps

module hci_uart_packet_deframer_core_test;

   localparam int KEEP_LIMIT = 128;
   localparam int IDLE_LIMIT = 1000;
   localparam int STALL_AT = 110;
   localparam int STALL_CYCLES = 80;
   localparam int MAX_REPORTS = 40;

   logic clock;
   logic reset = 1'b1;

   hcidf_req_if req_ch ();
   hcidf_rsp_if rsp_ch ();

   hci_uart_packet_deframer_core #(
      .KEEP_BYTES(KEEP_LIMIT)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   // Values driven onto the channels, known from time zero.
   logic       drv_valid = 1'b0;
   logic [7:0] drv_byte = 8'h00;
   logic       drv_ready = 1'b0;
   assign req_ch.valid = drv_valid;
   assign req_ch.byte_in = drv_byte;
   assign rsp_ch.ready = drv_ready;

   // UART bytes waiting to be offered, and packet bytes expected back.
   logic [7:0] uart_bytes [$];
   hcidf_pkg::result_type pending_frame_bytes [$];
   int items_queued = 0;
   int bytes_accepted = 0;
   int mismatch_count = 0;
   logic byte_taken = 1'b0;

   // Deframer state as the predictor sees it.
   hcidf_pkg::phase_type frame_phase = hcidf_pkg::PH_HUNT;
   logic       frame_kind = hcidf_pkg::KIND_EVENT;
   logic [8:0] frame_count = '0;
   logic [8:0] frame_total = '0;

   // Receiver long stall bookkeeping.
   bit stall_started = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;
   hcidf_pkg::result_type want;

   // Neither side idles while this window of the stream goes by.
   wire steady = (bytes_accepted >= 30) && (bytes_accepted < 90);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] exp,
                              input logic [8:0] index);
      if (got !== exp) begin
         report_mismatch($sformatf("%s got %0h, expected %0h (packet byte %0d)", name, got,
                                   exp, index));
      end
   endtask

   // Works out the packet byte, if any, that one received UART byte gives.
   task automatic deframe_byte(input logic [7:0] b);
      hcidf_pkg::result_type r;
      logic [8:0] idx;
      logic       last;
      r = '0;
      if (frame_phase != hcidf_pkg::PH_HEAD && frame_phase != hcidf_pkg::PH_BODY) begin
         if (b != hcidf_pkg::IND_ACL && b != hcidf_pkg::IND_EVENT) begin
            frame_phase = hcidf_pkg::PH_HUNT;
            return;
         end
         frame_kind = (b == hcidf_pkg::IND_ACL) ? hcidf_pkg::KIND_ACL : hcidf_pkg::KIND_EVENT;
         frame_count = 9'd1;
         frame_total = '0;
         frame_phase = hcidf_pkg::PH_HEAD;
         r.frame_byte = b;
         r.packet_kind = frame_kind;
         r.kept = (KEEP_LIMIT > 0);
         pending_frame_bytes.push_back(r);
         return;
      end
      idx = frame_count;
      // The length byte fixes the total and moves on to the body.
      if (frame_phase == hcidf_pkg::PH_HEAD &&
          idx == ((frame_kind == hcidf_pkg::KIND_ACL) ? hcidf_pkg::ACL_LEN_POS
                                                      : hcidf_pkg::EVT_LEN_POS)) begin
         frame_total = {1'b0, b} + ((frame_kind == hcidf_pkg::KIND_ACL) ? hcidf_pkg::ACL_EXTRA
                                                                         : hcidf_pkg::EVT_EXTRA);
         frame_phase = hcidf_pkg::PH_BODY;
      end
      last = (frame_phase == hcidf_pkg::PH_BODY) && (int'(idx) + 1 >= int'(frame_total));
      r.frame_byte = b;
      r.byte_index = idx;
      r.packet_kind = frame_kind;
      r.kept = (int'(idx) < KEEP_LIMIT);
      r.is_last = last;
      r.frame_length = last ? frame_total : 9'd0;
      pending_frame_bytes.push_back(r);
      if (last) begin
         frame_phase = hcidf_pkg::PH_HUNT;
         frame_count = '0;
      end else begin
         frame_count = idx + 9'd1;
      end
   endtask

   task automatic queue_byte(input logic [7:0] b);
      uart_bytes.push_back(b);
      items_queued++;
   endtask

   // Queues one well-formed packet with random header and payload.
   task automatic queue_packet(input logic acl, input int len);
      if (acl) begin
         queue_byte(hcidf_pkg::IND_ACL);
         queue_byte(8'($urandom_range(255)));
         queue_byte(8'($urandom_range(255)));
         queue_byte(8'(len));
         repeat (len + 1) queue_byte(8'($urandom_range(255)));
      end else begin
         queue_byte(hcidf_pkg::IND_EVENT);
         queue_byte(8'($urandom_range(255)));
         queue_byte(8'(len));
         repeat (len) queue_byte(8'($urandom_range(255)));
      end
   endtask

   // Mostly well-formed packets, some line noise and some cut-off packets.
   task automatic queue_random_traffic(input int budget);
      int first;
      int noise;
      int roll;
      int len;
      first = items_queued;
      noise = 0;
      while (items_queued - first - noise < budget) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            len = $urandom_range(3, 1);
            noise += len;
            repeat (len) queue_byte(8'($urandom_range(255)));
         end else if (roll < 20) begin
            queue_byte($urandom_range(1) ? hcidf_pkg::IND_ACL : hcidf_pkg::IND_EVENT);
            repeat ($urandom_range(3, 1)) queue_byte(8'($urandom_range(255)));
         end else begin
            roll = $urandom_range(99);
            if (roll < 85) begin
               len = $urandom_range(12);
            end else if (roll < 97) begin
               len = $urandom_range(40, 13);
            end else begin
               len = $urandom_range(160, 120);
            end
            queue_packet($urandom_range(1), len);
         end
      end
   endtask

   // Waits until every byte is in and every result is out.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (bytes_accepted != items_queued || pending_frame_bytes.size() != 0);
      // Hunting bytes give no result but may still be in flight.
      repeat (4) @(negedge clock);
   endtask

   // Sender: offers the next queued byte once the current one is taken.
   always @(negedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || byte_taken) begin
         if (uart_bytes.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
            drv_valid <= 1'b1;
            drv_byte <= uart_bytes.pop_front();
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off part way through.
   always @(negedge clock) begin
      if (!stall_started && bytes_accepted >= STALL_AT) begin
         stall_started = 1'b1;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         drv_ready <= 1'b0;
      end else begin
         drv_ready <= steady || ($urandom_range(99) >= 16);
      end
   end

   // Monitor: predict on each accepted byte, check each accepted result.
   always @(posedge clock) begin
      byte_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            bytes_accepted++;
            deframe_byte(req_ch.byte_in);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_frame_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected packet byte %0h at index %0d",
                                         rsp_ch.frame_byte, rsp_ch.byte_index));
            end else begin
               want = pending_frame_bytes.pop_front();
               check_field("frame_byte", 9'(rsp_ch.frame_byte), 9'(want.frame_byte),
                           want.byte_index);
               check_field("byte_index", rsp_ch.byte_index, want.byte_index, want.byte_index);
               check_field("packet_kind", 9'(rsp_ch.packet_kind), 9'(want.packet_kind),
                           want.byte_index);
               check_field("kept", 9'(rsp_ch.kept), 9'(want.kept), want.byte_index);
               check_field("is_last", 9'(rsp_ch.is_last), 9'(want.is_last), want.byte_index);
               check_field("frame_length", rsp_ch.frame_length, want.frame_length,
                           want.byte_index);
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("hci_uart_packet_deframer_core_test NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed packets, then two random phases with pauses between.
   initial begin
      logic [7:0] directed [$];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Noise while hunting, an empty event, an event carrying indicator
      // values as data, and the two shortest ACL packets.
      directed = '{8'h00, 8'hFF, 8'h80, 8'h03, 8'h01, 8'h7F,
                   hcidf_pkg::IND_EVENT, 8'h0E, 8'h00,
                   hcidf_pkg::IND_EVENT, hcidf_pkg::IND_ACL, 8'h02,
                   hcidf_pkg::IND_EVENT, hcidf_pkg::IND_ACL,
                   hcidf_pkg::IND_ACL, 8'hFF, 8'h0F, 8'h00, 8'h55,
                   hcidf_pkg::IND_ACL, 8'h00, 8'h00, 8'h01, 8'hAA, 8'hFF};
      foreach (directed[i]) queue_byte(directed[i]);
      wait_for_drain();

      @(posedge clock);
      queue_random_traffic(120);
      wait_for_drain();

      // The longest ACL packet reaches the top index and runs past the
      // keep limit.
      @(posedge clock);
      queue_random_traffic(30);
      queue_packet(hcidf_pkg::KIND_ACL, 255);
      queue_random_traffic(30);
      wait_for_drain();

      if (mismatch_count == 0) begin
         $display("hci_uart_packet_deframer_core_test OK");
      end else begin
         $display("hci_uart_packet_deframer_core_test NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/hcidf_pkg.sv
rtl/hcidf_if.sv
rtl/hcidf_in_stage.sv
rtl/hcidf_parser.sv
rtl/hcidf_out_stage.sv
rtl/hci_uart_packet_deframer_core.sv
rtl/hcidf_checker.sv
dv/hci_uart_packet_deframer_core_test.sv
